>>> rtl/ica_pkg.sv
// ============================================================================
// ica_pkg: shared definitions for the integer calculator ALU
// Command and status codes, the default word width and the control bundle
// that travels with each word down the pipeline.
// ============================================================================
package ica_pkg;

  localparam int unsigned DefDataWidth = 32;

  localparam logic [2:0] CmdAdd  = 3'd0;
  localparam logic [2:0] CmdSub  = 3'd1;
  localparam logic [2:0] CmdMul  = 3'd2;
  localparam logic [2:0] CmdDiv  = 3'd3;
  localparam logic [2:0] CmdSqrt = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDivZero = 2'd1;
  localparam logic [1:0] StNegRoot = 2'd2;
  localparam logic [1:0] StBadCmd  = 2'd3;

  // Control that rides along with the data of one word.
  typedef struct packed {
    logic       valid;
    logic [2:0] cmd;
    logic [1:0] status;
    logic       neg;     // quotient must be negated at the end
  } ctl_t;

endpackage

>>> rtl/integer_calculator_alu.sv
// ============================================================================
// integer_calculator_alu: pipelined add, sub, mul, div and square root
// One command word in, one result word out, in order, one word per cycle while the output is taken.
// ============================================================================
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | command, operand_a, operand_b
//  m_axis    | out       | result_value, status
//
// Every word passes through DATA_WIDTH+3 register stages: an input stage, a
// decode stage holding the add, subtract and product results and the operand
// magnitudes, DATA_WIDTH division stages (the first half of which also
// produce one square-root digit each), and the output register.
// A new word is accepted every cycle while the output moves on.
// The whole pipeline advances together; when the output word is not taken,
// every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits; the datapath registers need none.
//
module integer_calculator_alu import ica_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // command [2:0], operand_a, operand_b, zero fill
  input  logic [((3+2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // result_value, status [1:0], zero fill
  output logic [((2+DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned SW  = (W + 1) / 2;
  localparam int unsigned RW  = SW + 3;
  localparam int unsigned NW  = 2 * SW;
  localparam int unsigned OTW = ((2 + W + 7) / 8) * 8;

  logic en;

  // The pipeline moves whenever the output register is empty or drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage.
  logic         in_vld_q;
  logic [2:0]   in_cmd_q;
  logic [W-1:0] in_a_q, in_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_cmd_q <= s_axis_tdata[2:0];
      in_a_q   <= s_axis_tdata[3 +: W];
      in_b_q   <= s_axis_tdata[3+W +: W];
    end
  end

  // Decode stage: fast results, status, magnitudes and root operand.
  ctl_t         dec_ctl_d;
  logic [W-1:0] fast_d;
  logic [W-1:0] mag_a, mag_b;

  always_comb begin
    mag_a = in_a_q[W-1] ? (~in_a_q + 1'b1) : in_a_q;
    mag_b = in_b_q[W-1] ? (~in_b_q + 1'b1) : in_b_q;
    dec_ctl_d.valid  = in_vld_q;
    dec_ctl_d.cmd    = in_cmd_q;
    dec_ctl_d.neg    = in_a_q[W-1] ^ in_b_q[W-1];
    dec_ctl_d.status = StOk;
    case (in_cmd_q)
      CmdAdd:  fast_d = in_a_q + in_b_q;
      CmdSub:  fast_d = in_a_q - in_b_q;
      CmdMul:  fast_d = in_a_q * in_b_q;
      CmdDiv: begin
        fast_d = '0;
        if (in_b_q == '0) dec_ctl_d.status = StDivZero;
      end
      CmdSqrt: begin
        fast_d = '0;
        if (in_a_q[W-1]) dec_ctl_d.status = StNegRoot;
      end
      default: begin
        fast_d = '0;
        dec_ctl_d.status = StBadCmd;
      end
    endcase
  end

  // Stage chain; index 0 is the decode register.
  ctl_t          ctl_c  [0:W];
  logic [W-1:0]  fast_c [0:W];
  logic [W-1:0]  rem_c  [0:W];
  logic [W-1:0]  dq_c   [0:W];
  logic [W-1:0]  dvs_c  [0:W];
  logic [RW-1:0] sr_c   [0:W];
  logic [SW-1:0] sy_c   [0:W];
  logic [NW-1:0] sn_c   [0:W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c[0] <= '0;
    end else if (en) begin
      ctl_c[0] <= dec_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fast_c[0] <= fast_d;
      rem_c[0]  <= '0;
      dq_c[0]   <= mag_a;
      dvs_c[0]  <= mag_b;
      sr_c[0]   <= '0;
      sy_c[0]   <= '0;
      sn_c[0]   <= NW'(in_a_q);
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    ica_step #(
      .W       (W),
      .DO_SQRT (i < SW)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[i]),
      .fast_i (fast_c[i]),
      .rem_i  (rem_c[i]),
      .dq_i   (dq_c[i]),
      .dvs_i  (dvs_c[i]),
      .sr_i   (sr_c[i]),
      .sy_i   (sy_c[i]),
      .sn_i   (sn_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .fast_o (fast_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .dq_o   (dq_c[i+1]),
      .dvs_o  (dvs_c[i+1]),
      .sr_o   (sr_c[i+1]),
      .sy_o   (sy_c[i+1]),
      .sn_o   (sn_c[i+1])
    );
  end

  // Output stage: pick the result and apply the quotient sign.
  ctl_t         last;
  logic [W-1:0] res_d;
  logic [W-1:0] res_q;
  logic [1:0]   st_q;
  logic         out_vld_q;

  assign last = ctl_c[W];

  always_comb begin
    if (last.status != StOk) begin
      res_d = '0;
    end else begin
      case (last.cmd)
        CmdDiv:  res_d = last.neg ? (~dq_c[W] + 1'b1) : dq_c[W];
        CmdSqrt: res_d = W'(sy_c[W]);
        default: res_d = fast_c[W];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      st_q  <= last.status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OTW'({st_q, res_q});

endmodule

>>> rtl/ica_step.sv
// ============================================================================
// ica_step: one pipeline stage of the divide and square-root datapath
// Performs one restoring-division step and, if enabled, one digit of the
// square root, then registers everything along with the word's control.
// ============================================================================
module ica_step import ica_pkg::*; #(
  parameter int unsigned W       = DefDataWidth,
  parameter bit          DO_SQRT = 1'b1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ctl_t                    ctl_i,
  input  logic [W-1:0]            fast_i,
  input  logic [W-1:0]            rem_i,
  input  logic [W-1:0]            dq_i,
  input  logic [W-1:0]            dvs_i,
  input  logic [(W+1)/2+2:0]      sr_i,
  input  logic [(W+1)/2-1:0]      sy_i,
  input  logic [2*((W+1)/2)-1:0]  sn_i,
  output ctl_t                    ctl_o,
  output logic [W-1:0]            fast_o,
  output logic [W-1:0]            rem_o,
  output logic [W-1:0]            dq_o,
  output logic [W-1:0]            dvs_o,
  output logic [(W+1)/2+2:0]      sr_o,
  output logic [(W+1)/2-1:0]      sy_o,
  output logic [2*((W+1)/2)-1:0]  sn_o
);

  localparam int unsigned SW = (W + 1) / 2;
  localparam int unsigned RW = SW + 3;
  localparam int unsigned NW = 2 * SW;

  logic [W:0]    trem;
  logic [W:0]    tdif;
  logic [W-1:0]  rem_d, dq_d;
  logic [RW-1:0] sr2, strial, sdif, sr_d;
  logic [SW-1:0] sy_d;
  logic [NW-1:0] sn_d;

  // Division: bring down the next dividend bit and try to subtract.
  always_comb begin
    trem = {rem_i, dq_i[W-1]};
    tdif = trem - {1'b0, dvs_i};
    if (!tdif[W]) begin
      rem_d = tdif[W-1:0];
      dq_d  = {dq_i[W-2:0], 1'b1};
    end else begin
      rem_d = trem[W-1:0];
      dq_d  = {dq_i[W-2:0], 1'b0};
    end
  end

  // Square root: bring down two bits and try 4y+1.
  always_comb begin
    sr2    = {sr_i[RW-3:0], sn_i[NW-1:NW-2]};
    strial = {1'b0, sy_i, 2'b01};
    sdif   = sr2 - strial;
    if (!DO_SQRT) begin
      sr_d = sr_i;
      sy_d = sy_i;
      sn_d = sn_i;
    end else if (sr2 >= strial) begin
      sr_d = sdif;
      sy_d = {sy_i[SW-2:0], 1'b1};
      sn_d = {sn_i[NW-3:0], 2'b00};
    end else begin
      sr_d = sr2;
      sy_d = {sy_i[SW-2:0], 1'b0};
      sn_d = {sn_i[NW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fast_o <= fast_i;
      rem_o  <= rem_d;
      dq_o   <= dq_d;
      dvs_o  <= dvs_i;
      sr_o   <= sr_d;
      sy_o   <= sy_d;
      sn_o   <= sn_d;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the integer calculator ALU
// Drives command words through the slave stream, predicts each result word
// from the operands, and compares the master stream in order. A directed
// table covers extremes and error cases, then random traffic runs under
// several idle and stall patterns, including a long output hold-off.
// ============================================================================
module tb_top import ica_pkg::*;;

  localparam int unsigned DW       = 32;
  localparam int unsigned IN_W     = ((3 + 2 * DW + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((2 + DW + 7) / 8) * 8;
  localparam int unsigned LIMIT    = 400000;
  localparam int          HOLD_LEN = 300;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
  } op_word_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic [1:0]    status;
  } res_word_t;

  // One directed row: the operation, and a typed-in answer where it is obvious.
  typedef struct {
    op_word_t  op;
    bit        known;
    res_word_t res;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // command, operand_a, operand_b, zero fill
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;   // result_value, status, zero fill

  res_word_t pending_results[$];
  int        errors = 0;
  int        row_errs;
  int        cycles = 0;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_req;
  bit        hold_taken = 1'b0;
  int        hold_cnt = 0;

  integer_calculator_alu #(.DATA_WIDTH(DW)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Floor square root by the digit-by-digit method on a 32-bit argument.
  function automatic logic [DW-1:0] root_floor(logic [DW-1:0] n);
    logic [DW-1:0] rem;
    logic [DW-1:0] acc;
    logic [DW-1:0] bitv;
    rem  = n;
    acc  = '0;
    bitv = 1 << (DW - 2);
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem = rem - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // Expected result word for one command word.
  function automatic res_word_t alu_result(op_word_t op);
    res_word_t     r;
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW-1:0] quo;
    r.value  = '0;
    r.status = StOk;
    mag_a = op.opa[DW-1] ? -op.opa : op.opa;
    mag_b = op.opb[DW-1] ? -op.opb : op.opb;
    case (op.cmd)
      CmdAdd: r.value = op.opa + op.opb;
      CmdSub: r.value = op.opa - op.opb;
      CmdMul: r.value = op.opa * op.opb;
      CmdDiv: begin
        if (op.opb == '0) begin
          r.status = StDivZero;
        end else begin
          // Unsigned magnitudes make INT_MIN / -1 wrap to INT_MIN.
          quo = mag_a / mag_b;
          r.value = (op.opa[DW-1] != op.opb[DW-1]) ? -quo : quo;
        end
      end
      CmdSqrt: begin
        if (op.opa[DW-1]) r.status = StNegRoot;
        else r.value = root_floor(op.opa);
      end
      default: r.status = StBadCmd;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return DW'($urandom_range(0, 20) - 10);
      5: return DW'($urandom_range(0, 65535));
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic op_word_t rand_op();
    op_word_t op;
    op.cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    op.opa = rand_operand();
    op.opb = rand_operand();
    return op;
  endfunction

  // Offers one word, honoring the sender idle rate, and waits for acceptance.
  // Valid stays high afterwards until the next idle cycle or the end of input.
  task automatic send_word(op_word_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({op.opb, op.opa, op.cmd});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Queue the expectation on the edge that accepts the word.
  always @(posedge clk_i) begin
    op_word_t op;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      op.cmd = s_axis_tdata[2:0];
      op.opa = s_axis_tdata[3 +: DW];
      op.opb = s_axis_tdata[3 + DW +: DW];
      pending_results.push_back(alu_result(op));
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    res_word_t exp_r;
    logic [DW-1:0] got_value;
    logic [1:0]    got_status;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value  = m_axis_tdata[DW-1:0];
      got_status = m_axis_tdata[DW +: 2];
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: value %0h status %0d",
               got_value, got_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_value !== exp_r.value) begin
          $error("result_value: expected %0h, got %0h", exp_r.value, got_value);
          errors++;
        end
        if (got_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got_status);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_cnt      <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed rows: extremes, every command, each error path.
  localparam logic [DW-1:0] MIN_I = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_I = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] ONES  = '1;

  row_t directed[$];

  task automatic add_row(logic [2:0] c, logic [DW-1:0] a, logic [DW-1:0] b,
                         bit k, logic [DW-1:0] v, logic [1:0] s);
    row_t r;
    r.op    = '{c, a, b};
    r.known = k;
    r.res   = '{v, s};
    directed.push_back(r);
  endtask

  initial begin
    op_word_t  op;
    res_word_t chk;
    int        n;
    int        phase;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    rst_ni         = 1'b0;
    row_errs       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;

    add_row(CmdAdd,  MAX_I, 1,     1, MIN_I, StOk);
    add_row(CmdAdd,  MIN_I, ONES,  1, MAX_I, StOk);
    add_row(CmdAdd,  0,     0,     1, 0,     StOk);
    add_row(CmdSub,  MIN_I, 1,     1, MAX_I, StOk);
    add_row(CmdSub,  0,     MIN_I, 1, MIN_I, StOk);
    add_row(CmdMul,  MAX_I, MAX_I, 1, 1,     StOk);
    add_row(CmdMul,  MIN_I, ONES,  1, MIN_I, StOk);
    add_row(CmdMul,  12345, ONES,  0, 0,     StOk);
    add_row(CmdDiv,  MIN_I, ONES,  1, MIN_I, StOk);
    add_row(CmdDiv,  7,     0,     1, 0,     StDivZero);
    add_row(CmdDiv,  0,     0,     1, 0,     StDivZero);
    add_row(CmdDiv,  ONES * 7, 2,  1, ONES * 3, StOk);
    add_row(CmdDiv,  MAX_I, MIN_I, 1, 0,     StOk);
    add_row(CmdDiv,  MIN_I, MIN_I, 1, 1,     StOk);
    add_row(CmdSqrt, MAX_I, ONES,  1, 46340, StOk);
    add_row(CmdSqrt, 0,     0,     1, 0,     StOk);
    add_row(CmdSqrt, 24,    0,     1, 4,     StOk);
    add_row(CmdSqrt, 25,    0,     1, 5,     StOk);
    add_row(CmdSqrt, ONES,  0,     1, 0,     StNegRoot);
    add_row(CmdSqrt, MIN_I, 0,     1, 0,     StNegRoot);
    add_row(3'd5,    MAX_I, 1,     1, 0,     StBadCmd);
    add_row(3'd6,    0,     0,     1, 0,     StBadCmd);
    add_row(3'd7,    ONES,  ONES,  1, 0,     StBadCmd);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      // Hand-typed answers guard the predictor itself.
      chk = alu_result(directed[i].op);
      if (directed[i].known && chk !== directed[i].res) begin
        $error("table row %0d: expected %0h, predictor gives %0h",
               i, directed[i].res, chk);
        row_errs++;
      end
      send_word(directed[i].op);
    end

    // Random traffic in four idle and stall patterns, long hold-off in the second.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 16 : 0;
      recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 16 : 0;
      if (phase == 1) hold_req = 1'b1;
      for (n = 0; n < 260; n++) begin
        op = rand_op();
        send_word(op);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DW + 20) @(posedge clk_i);

    if (errors == 0 && row_errs == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
